[src/sll_pkg.sv]
// Shared types, constants and character classes for the stack language lexer.
package sll_pkg;

  // Positions, lengths and ordinals share one saturating width.
  localparam int unsigned PosBits = 16;
  localparam logic [PosBits-1:0] PosMax = '1;

  // A byte causes at most three results.
  localparam int unsigned ResultsMax = 3;
  localparam int unsigned CntBits = $clog2(ResultsMax + 1);

  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChLparen  = 8'h28;
  localparam logic [7:0] ChRparen  = 8'h29;
  localparam logic [7:0] ChLbrace  = 8'h7B;
  localparam logic [7:0] ChRbrace  = 8'h7D;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_LBRACE  = 3'd2,
    KIND_RBRACE  = 3'd3,
    KIND_ASM     = 3'd4,
    KIND_INVALID = 3'd5,
    KIND_END     = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e              token_kind;
    logic [PosBits-1:0] token_start;
    logic [PosBits-1:0] token_length;
    logic [7:0]         bad_char;
    logic [PosBits-1:0] token_index;
    logic               last_result;
  } token_t;

  // All results of one byte, handed to the result buffer in one go.
  typedef struct packed {
    token_t [ResultsMax-1:0] tok;
    logic [CntBits-1:0]      n;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    logic hit;
    hit = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    unique case (c)
      "+", "-", "/", "*", "_", "%", "^", "|", "&", "~", "!", "<", ">", "=", ".",
      "?": hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  // Clamp a value that carries one extra bit back into position range.
  function automatic logic [PosBits-1:0] sat_wide(input logic [PosBits:0] v);
    return v[PosBits] ? PosMax : v[PosBits-1:0];
  endfunction

  function automatic token_t make_token(input kind_e kind,
                                        input logic [PosBits-1:0] start,
                                        input logic [PosBits-1:0] len,
                                        input logic [7:0] bad,
                                        input logic [PosBits-1:0] idx);
    token_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.bad_char     = bad;
    t.token_index  = idx;
    t.last_result  = 1'b0;
    return t;
  endfunction

endpackage

[src/sll_if.sv]
// Valid/ready channel interfaces for source bytes and token words.
interface sll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sll_out_if;
  import sll_pkg::*;
  logic               valid;
  logic               ready;
  kind_e              token_kind;
  logic [PosBits-1:0] token_start;
  logic [PosBits-1:0] token_length;
  logic [7:0]         bad_char;
  logic [PosBits-1:0] token_index;
  logic               last_result;

  modport source(output valid, output token_kind, output token_start,
                 output token_length, output bad_char, output token_index,
                 output last_result, input ready);
  modport sink(input valid, input token_kind, input token_start,
               input token_length, input bad_char, input token_index,
               input last_result, output ready);
endinterface

[src/stack_language_lexer.sv]
// Top level of the streaming stack language lexer.
// Path: an accepted byte waits in the input register, and its words then wait
//   in the result buffer until the output takes them.
// Throughput: one byte per cycle while out_o is ready and each byte yields at
//   most one word; a byte with 2 or 3 words holds the input till its last leaves.
// Reset (asynchronous, active low): idle mode, positions and count at zero,
//   input register and result buffer empty. End of text also clears state.
module stack_language_lexer (
  input logic       clk_i,
  input logic       rst_ni,
  sll_in_if.sink    in_i,
  sll_out_if.source out_o
);
  import sll_pkg::*;

  // Core to buffer: the words of the byte in the input register, and the
  // handshake that moves them. The core commits its mode, position, run
  // start and token count only on the cycle the words are loaded, so a
  // stalled output simply freezes the lexer with the byte still held.
  logic   load;
  logic   can_load;
  batch_t batch;

  // Input register plus all per-byte lexing: closing a run, lexing the byte
  // from idle, and the end-of-text flush with its end word.
  sll_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .can_load_i (can_load),
    .load_o     (load),
    .batch_o    (batch)
  );

  // Result buffer: up to three words, shifted out one per accepted word.
  // It takes a new batch when empty or when its final word leaves this cycle,
  // so single-word bytes stream back to back.
  sll_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .batch_i    (batch),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

[src/sll_core.sv]
// Input register, lexer mode state and per-byte token logic.
module sll_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  sll_in_if.sink          in_i,
  input  logic            can_load_i,
  output logic            load_o,
  output sll_pkg::batch_t batch_o
);
  import sll_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_IDENT   = 3'd3;
  localparam logic [2:0] MODE_NUMBER  = 3'd4;
  localparam logic [2:0] MODE_ASM     = 3'd5;

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic               eot_q;

  logic [2:0]         mode_q, mode_d, mode_step;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] run_q, run_d, run_step;
  logic [PosBits-1:0] tokens_q, tokens_d, cnt_tmp;
  logic               relex;
  logic [PosBits:0]   end_pos, run_len;
  token_t [ResultsMax-1:0] res;
  logic [CntBits-1:0] n;

  // Input register: the byte waits here until its words fit the result buffer.
  assign load_o     = in_valid_q && can_load_i;
  assign in_i.ready = !in_valid_q || load_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (load_o) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
      eot_q  <= in_i.end_of_text;
    end
  end

  always_comb begin
    mode_step = mode_q;
    run_step  = run_q;
    cnt_tmp   = tokens_q;
    relex     = 1'b0;
    n         = '0;
    res       = '0;

    // Close or continue the open run.
    unique case (mode_q)
      MODE_COMMENT: begin
        if (byte_q == ChNewline) mode_step = MODE_IDLE;
      end
      MODE_STRING: begin
        if (byte_q == ChQuote) mode_step = MODE_IDLE;
      end
      MODE_ASM: begin
        if (byte_q == ChRparen) begin
          res[n]    = make_token(KIND_ASM, run_q, pos_q - run_q, '0, cnt_tmp);
          cnt_tmp   = sat_inc(cnt_tmp);
          n         = n + CntBits'(1);
          mode_step = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (!is_name_char(byte_q)) begin
          res[n]    = make_token(KIND_IDENT, run_q, pos_q - run_q, '0, cnt_tmp);
          cnt_tmp   = sat_inc(cnt_tmp);
          n         = n + CntBits'(1);
          mode_step = MODE_IDLE;
          relex     = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_digit(byte_q)) begin
          res[n]    = make_token(KIND_NUMBER, run_q, pos_q - run_q, '0, cnt_tmp);
          cnt_tmp   = sat_inc(cnt_tmp);
          n         = n + CntBits'(1);
          mode_step = MODE_IDLE;
          relex     = 1'b1;
        end
      end
      default: begin
        mode_step = MODE_IDLE;
        relex     = 1'b1;
      end
    endcase

    // Lex the byte from idle.
    if (relex) begin
      priority if (byte_q == ChHash) begin
        mode_step = MODE_COMMENT;
      end else if (byte_q == ChQuote) begin
        mode_step = MODE_STRING;
      end else if (is_space(byte_q)) begin
      end else if (is_name_char(byte_q)) begin
        mode_step = MODE_IDENT;
        run_step  = pos_q;
      end else if (byte_q == ChLparen) begin
        mode_step = MODE_ASM;
        run_step  = sat_inc(pos_q);
      end else if (is_digit(byte_q)) begin
        mode_step = MODE_NUMBER;
        run_step  = pos_q;
      end else if (byte_q == ChLbrace) begin
        res[n]  = make_token(KIND_LBRACE, pos_q, PosBits'(1), '0, cnt_tmp);
        cnt_tmp = sat_inc(cnt_tmp);
        n       = n + CntBits'(1);
      end else if (byte_q == ChRbrace) begin
        res[n]  = make_token(KIND_RBRACE, pos_q, PosBits'(1), '0, cnt_tmp);
        cnt_tmp = sat_inc(cnt_tmp);
        n       = n + CntBits'(1);
      end else begin
        // invalid char: reported, not counted
        res[n] = make_token(KIND_INVALID, pos_q, PosBits'(1), byte_q, cnt_tmp);
        n      = n + CntBits'(1);
      end
    end

    // End of text: flush an open run, then the end word.
    end_pos = {1'b0, pos_q} + 1'b1;
    run_len = end_pos - {1'b0, run_step};
    if (eot_q) begin
      if (mode_step == MODE_IDENT) begin
        res[n]  = make_token(KIND_IDENT, run_step, sat_wide(run_len), '0, cnt_tmp);
        cnt_tmp = sat_inc(cnt_tmp);
        n       = n + CntBits'(1);
      end else if (mode_step == MODE_NUMBER) begin
        res[n]  = make_token(KIND_NUMBER, run_step, sat_wide(run_len), '0, cnt_tmp);
        cnt_tmp = sat_inc(cnt_tmp);
        n       = n + CntBits'(1);
      end else if (mode_step == MODE_ASM) begin
        res[n]  = make_token(KIND_ASM, run_step, sat_wide(run_len), '0, cnt_tmp);
        cnt_tmp = sat_inc(cnt_tmp);
        n       = n + CntBits'(1);
      end
      res[n] = make_token(KIND_END, sat_wide(end_pos), '0, '0, cnt_tmp);
      n      = n + CntBits'(1);
    end

    for (int i = 0; i < ResultsMax; i++) begin
      res[i].last_result = (CntBits'(i) == n - CntBits'(1));
    end
  end

  assign batch_o.tok = res;
  assign batch_o.n   = n;

  // End of text returns everything to the reset state.
  assign mode_d   = eot_q ? MODE_IDLE : mode_step;
  assign pos_d    = eot_q ? '0 : sat_inc(pos_q);
  assign run_d    = eot_q ? '0 : run_step;
  assign tokens_d = eot_q ? '0 : cnt_tmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      run_q    <= '0;
      tokens_q <= '0;
    end else if (load_o) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      run_q    <= run_d;
      tokens_q <= tokens_d;
    end
  end

  a_eot_has_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o && eot_q |-> batch_o.n != '0)
    else $error("end of text produced no end word");

  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o && eot_q |=> pos_q == '0 && mode_q == MODE_IDLE && tokens_q == '0)
    else $error("state not cleared after end of text");

  a_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !load_o |=> in_valid_q && $stable(byte_q) && $stable(eot_q))
    else $error("pending byte lost or changed");

endmodule

[src/sll_outbuf.sv]
// Result buffer: holds the words of one byte and hands them out in order.
module sll_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sll_pkg::batch_t batch_i,
  output logic            can_load_o,
  sll_out_if.source       out_o
);
  import sll_pkg::*;

  token_t             slot_q [ResultsMax];
  logic [CntBits-1:0] cnt_q;
  logic               pop;

  assign out_o.valid  = (cnt_q != '0);
  assign pop          = out_o.valid && out_o.ready;
  // New words may enter when the buffer is empty or drains this cycle.
  assign can_load_o   = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_o.ready);

  assign out_o.token_kind   = slot_q[0].token_kind;
  assign out_o.token_start  = slot_q[0].token_start;
  assign out_o.token_length = slot_q[0].token_length;
  assign out_o.bad_char     = slot_q[0].bad_char;
  assign out_o.token_index  = slot_q[0].token_index;
  assign out_o.last_result  = slot_q[0].last_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < ResultsMax; i++) begin
        slot_q[i] <= batch_i.tok[i];
      end
    end else if (pop) begin
      for (int i = 0; i < ResultsMax - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> cnt_q == '0 || (cnt_q == CntBits'(1) && pop))
    else $error("load over undelivered words");

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntBits'(1) |-> slot_q[0].last_result)
    else $error("final buffered word not marked last");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && batch_i.n != '0 |=> out_o.valid)
    else $error("loaded words not presented");

endmodule
